### rtl/core/rbc_pkg.sv
// package for the reconnect backoff controller
// holds the link mode type, operation and status codes, register indexes and shared structs
// no dependencies
`timescale 1ns / 1ps

package rbc_pkg;

    typedef enum logic [1:0] {
        MODE_DISC         = 2'd0,
        MODE_CONNECTING   = 2'd1,
        MODE_CONNECTED    = 2'd2,
        MODE_RECONNECTING = 2'd3
    } t_mode;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_FORCE = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_WAIT        = 2'd1;
    localparam logic [1:0] STATUS_NOT_STARTED = 2'd2;

    localparam logic [1:0] REG_INITIAL_BACKOFF = 2'd0;
    localparam logic [1:0] REG_MAX_BACKOFF     = 2'd1;
    localparam logic [1:0] REG_KEEPALIVE       = 2'd2;

    localparam logic [31:0] INITIAL_BACKOFF_RST = 32'd1000;
    localparam logic [31:0] MAX_BACKOFF_RST     = 32'd60000;
    localparam logic [31:0] KEEPALIVE_RST       = 32'd2000;

    localparam int unsigned PADDR_W = 4;

    typedef struct packed {
        logic [31:0] initial_backoff;
        logic [31:0] max_backoff;
        logic [31:0] keepalive_interval;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic        link_up;
        logic [31:0] backoff;
        logic [31:0] attempt_stamp;
        logic [31:0] keepalive_stamp;
        logic [31:0] streak;
        logic [31:0] retries;
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        t_mode       link_state;
        logic        attempt_made;
        logic        keepalive_due;
        logic        connected;
        logic [31:0] backoff_now;
        logic [31:0] consecutive_failures;
        logic [31:0] total_retries;
    } t_result;

endpackage

### rtl/core/rbc_step.sv
// next-state and result logic for one item of the reconnect backoff controller
// depends on rbc_pkg
`timescale 1ns / 1ps

module rbc_step (
    input  rbc_pkg::t_state  i_state,
    input  rbc_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_operation,
    input  logic [31:0]      i_now_ms,
    input  logic             i_connect_ok,
    output rbc_pkg::t_state  o_next,
    output rbc_pkg::t_result o_result
);
    import rbc_pkg::*;

    logic [31:0] attempt_elapsed;
    logic [31:0] keep_elapsed;
    logic        backoff_pending;
    logic        keep_expired;
    logic [32:0] backoff_x2;
    logic [31:0] backoff_dbl;
    logic        is_poll;
    logic        is_retry_mode;

    assign attempt_elapsed = i_now_ms - i_state.attempt_stamp;
    assign keep_elapsed    = i_now_ms - i_state.keepalive_stamp;
    assign backoff_pending = attempt_elapsed < i_state.backoff;
    assign keep_expired    = keep_elapsed > i_cfg.keepalive_interval;
    assign is_poll         = (i_operation == OP_POLL);
    assign is_retry_mode   = (i_state.mode == MODE_CONNECTING)
                          || (i_state.mode == MODE_RECONNECTING);

    // doubling kept at 33 bits so it cannot wrap before the clamp
    assign backoff_x2  = {i_state.backoff, 1'b0};
    assign backoff_dbl = (backoff_x2 > {1'b0, i_cfg.max_backoff})
                       ? i_cfg.max_backoff : backoff_x2[31:0];

    // next state
    always_comb begin
        o_next = i_state;
        case (i_operation)
            OP_START: begin
                if (i_state.mode != MODE_CONNECTED) begin
                    o_next.mode          = MODE_CONNECTING;
                    o_next.attempt_stamp = i_now_ms;
                end
            end
            OP_POLL: begin
                if (i_state.mode == MODE_CONNECTED) begin
                    if (keep_expired) begin
                        o_next.keepalive_stamp = i_now_ms;
                    end
                end else if (is_retry_mode && !backoff_pending) begin
                    o_next.attempt_stamp = i_now_ms;
                    if (i_connect_ok) begin
                        o_next.mode            = MODE_CONNECTED;
                        o_next.link_up         = 1'b1;
                        o_next.streak          = '0;
                        o_next.backoff         = i_cfg.initial_backoff;
                        o_next.keepalive_stamp = i_now_ms;
                    end else begin
                        o_next.mode    = MODE_RECONNECTING;
                        o_next.streak  = i_state.streak + 32'd1;
                        o_next.retries = i_state.retries + 32'd1;
                        o_next.backoff = backoff_dbl;
                    end
                end
            end
            OP_FORCE: begin
                o_next.link_up       = 1'b0;
                o_next.mode          = MODE_RECONNECTING;
                o_next.backoff       = i_cfg.initial_backoff;
                o_next.attempt_stamp = '0;
            end
            default: begin
                o_next = i_state;
            end
        endcase
    end

    // result fields
    always_comb begin
        o_result.status               = STATUS_OK;
        o_result.attempt_made         = 1'b0;
        o_result.keepalive_due        = 1'b0;
        if (is_poll) begin
            case (i_state.mode)
                MODE_DISC: begin
                    o_result.status = STATUS_NOT_STARTED;
                end
                MODE_CONNECTED: begin
                    o_result.keepalive_due = keep_expired;
                end
                default: begin
                    o_result.attempt_made = !backoff_pending;
                    if (backoff_pending || !i_connect_ok) begin
                        o_result.status = STATUS_WAIT;
                    end
                end
            endcase
        end
        o_result.link_state           = o_next.mode;
        o_result.connected            = o_next.link_up && (o_next.mode == MODE_CONNECTED);
        o_result.backoff_now          = o_next.backoff;
        o_result.consecutive_failures = o_next.streak;
        o_result.total_retries        = o_next.retries;
    end

endmodule

### rtl/core/reconnect_backoff_controller.sv
// Reconnect backoff controller, top level.
// Input channel: i_in_valid / o_in_stall with i_operation, i_now_ms, i_connect_ok.
// Output channel: o_out_valid / i_out_stall with one result item per input item.
// Configuration: APB-style write/read port, registers at byte addresses 0, 4 and 8
// (initial backoff, maximum backoff, keepalive interval), pready always high.
// An accepted item is registered in the input register, worked on by rbc_step
// and its result loaded into the result register, from which it is taken.
// Throughput: one item per cycle while the receiver does not stall; the link
// state registers update in the same cycle the result register loads, so the
// next item sees them at once.
// When the receiver stalls, the result register holds; one more item may sit in
// the input register, after which o_in_stall rises until the result is taken.
// Reset (synchronous, active low) empties both registers, puts the link in the
// disconnected mode with counters at zero and restores the register defaults.
// Depends on rbc_pkg and rbc_step.
`timescale 1ns / 1ps

module reconnect_backoff_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_connect_ok,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_link_state,
    output logic                          o_attempt_made,
    output logic                          o_keepalive_due,
    output logic                          o_connected,
    output logic [31:0]                   o_backoff_now,
    output logic [31:0]                   o_consecutive_failures,
    output logic [31:0]                   o_total_retries,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rbc_pkg::*;

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     r_res;
    t_result     n_res;
    logic        r_in_valid;
    logic        r_out_valid;
    logic [1:0]  r_operation;
    logic [31:0] r_now_ms;
    logic        r_connect_ok;
    logic        advance;
    logic        in_take;
    logic        cfg_write;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[PADDR_W-1:2];

    // the worked item moves on when the result register is free or being emptied
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_backoff    <= INITIAL_BACKOFF_RST;
            r_cfg.max_backoff        <= MAX_BACKOFF_RST;
            r_cfg.keepalive_interval <= KEEPALIVE_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_INITIAL_BACKOFF: r_cfg.initial_backoff    <= pwdata;
                REG_MAX_BACKOFF:     r_cfg.max_backoff        <= pwdata;
                REG_KEEPALIVE:       r_cfg.keepalive_interval <= pwdata;
                default:             r_cfg                    <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_INITIAL_BACKOFF: prdata = r_cfg.initial_backoff;
            REG_MAX_BACKOFF:     prdata = r_cfg.max_backoff;
            REG_KEEPALIVE:       prdata = r_cfg.keepalive_interval;
            default:             prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_operation  <= i_operation;
            r_now_ms     <= i_now_ms;
            r_connect_ok <= i_connect_ok;
        end
    end

    rbc_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_operation  (r_operation),
        .i_now_ms     (r_now_ms),
        .i_connect_ok (r_connect_ok),
        .o_next       (n_state),
        .o_result     (n_res)
    );

    // link state and result register load together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= MODE_DISC;
            r_state.link_up         <= 1'b0;
            r_state.backoff         <= INITIAL_BACKOFF_RST;
            r_state.attempt_stamp   <= '0;
            r_state.keepalive_stamp <= '0;
            r_state.streak          <= '0;
            r_state.retries         <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_res.status;
    assign o_link_state           = r_res.link_state;
    assign o_attempt_made         = r_res.attempt_made;
    assign o_keepalive_due        = r_res.keepalive_due;
    assign o_connected            = r_res.connected;
    assign o_backoff_now          = r_res.backoff_now;
    assign o_consecutive_failures = r_res.consecutive_failures;
    assign o_total_retries        = r_res.total_retries;

endmodule

### rtl/core/rbc_checker.sv
// port-level checks for the reconnect backoff controller, bound to the top level
// depends on rbc_pkg and reconnect_backoff_controller
`timescale 1ns / 1ps

module rbc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_status,
    input logic [1:0]                  o_link_state,
    input logic                        o_attempt_made,
    input logic                        o_keepalive_due,
    input logic                        o_connected,
    input logic [31:0]                 o_consecutive_failures
);
    import rbc_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a successful attempt clears the failure streak and reports ok
    a_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_attempt_made && o_connected |->
            o_consecutive_failures == 32'd0 && o_status == STATUS_OK)
        else $error("success without streak clear");

    // keepalive only flagged on a connected link
    a_keepalive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_keepalive_due |->
            o_link_state == MODE_CONNECTED && !o_attempt_made && o_status == STATUS_OK)
        else $error("keepalive outside connected mode");

    // connected flag implies connected mode
    a_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_connected |-> o_link_state == MODE_CONNECTED)
        else $error("connected flag in wrong mode");

endmodule

bind reconnect_backoff_controller rbc_checker u_rbc_checker (.*);
